FILE: sv/tcpr_pkg.sv
// tcpr_pkg: shared types and constants of the terminal cell pixel renderer
// used by the channel interfaces and every module of the block; no dependencies
`default_nettype none

package tcpr_pkg;

   localparam int PIXEL_WIDTH     = 8;
   localparam int GLYPH_WIDTH     = 8;
   localparam int COLOR_WIDTH     = 8;
   localparam int SUM_WIDTH       = 11;
   localparam int COUNT_WIDTH     = 4;
   localparam int POS_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 2;

   localparam int TCPR_QUEUE_DEPTH = 2;

   // render modes; the unused code renders as braille
   localparam logic [1:0] MODE_ASCII   = 2'd0;
   localparam logic [1:0] MODE_SHADE   = 2'd1;
   localparam logic [1:0] MODE_BRAILLE = 2'd2;

   // palette modes; the unused code maps to the cube
   localparam logic [1:0] PAL_NONE  = 2'd0;
   localparam logic [1:0] PAL_BASIC = 2'd1;
   localparam logic [1:0] PAL_CUBE  = 2'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RENDER_MODE     = 3'd0,
      CSR_INVERT_ENABLE   = 3'd1,
      CSR_COLOR_ENABLE    = 3'd2,
      CSR_FRAME_HAS_COLOR = 3'd3,
      CSR_PALETTE_MODE    = 3'd4
   } tcpr_csr_type;

   typedef struct packed {
      logic [1:0] render_mode;
      logic       invert_enable;
      logic       color_enable;
      logic       frame_has_color;
      logic [1:0] palette_mode;
   } tcpr_cfg_type;

   localparam tcpr_cfg_type CFG_RESET = '{
      render_mode:     MODE_SHADE,
      invert_enable:   1'b0,
      color_enable:    1'b1,
      frame_has_color: 1'b0,
      palette_mode:    PAL_CUBE
   };

   // one job in the queue: a ramp pixel or a finished braille cell
   typedef struct packed {
      logic                   is_cell;
      logic [GLYPH_WIDTH-1:0] glyph;
      logic [SUM_WIDTH-1:0]   red_sum;
      logic [SUM_WIDTH-1:0]   green_sum;
      logic [SUM_WIDTH-1:0]   blue_sum;
      logic [COUNT_WIDTH-1:0] lit_count;
   } tcpr_job_type;

endpackage

`default_nettype wire

FILE: sv/tcpr_pixel_if.sv
// tcpr_pixel_if: valid/ready channel carrying one sampled pixel
// depends on tcpr_pkg for the field widths
`default_nettype none

interface tcpr_pixel_if import tcpr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] gray;
   logic [PIXEL_WIDTH-1:0] red;
   logic [PIXEL_WIDTH-1:0] green;
   logic [PIXEL_WIDTH-1:0] blue;

   modport source (output valid, gray, red, green, blue, input ready);
   modport sink   (input valid, gray, red, green, blue, output ready);
endinterface

`default_nettype wire

FILE: sv/tcpr_cell_if.sv
// tcpr_cell_if: valid/ready channel carrying one rendered terminal cell
// depends on tcpr_pkg for the field widths
`default_nettype none

interface tcpr_cell_if import tcpr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [GLYPH_WIDTH-1:0] glyph_code;
   logic                   blank_cell;
   logic                   color_valid;
   logic [COLOR_WIDTH-1:0] color_code;

   modport source (output valid, glyph_code, blank_cell, color_valid, color_code,
                   input ready);
   modport sink   (input valid, glyph_code, blank_cell, color_valid, color_code,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/tcpr_front.sv
// tcpr_front: accepts pixels, applies inversion, ramps and braille dithering
// depends on tcpr_pkg and tcpr_pixel_if; pushes jobs into tcpr_queue
`default_nettype none

module tcpr_front import tcpr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tcpr_cfg_type cfg,
   tcpr_pixel_if.sink        req_pixel,
   input  wire logic         queue_full,
   output logic              push,
   output tcpr_job_type      push_job
);

   localparam logic [POS_WIDTH-1:0] CELL_LAST = POS_WIDTH'(7);

   // (order + 1) * 255 / 9 for the dither order at each position
   function automatic logic [PIXEL_WIDTH-1:0] dither_threshold(input logic [POS_WIDTH-1:0] p);
      logic [PIXEL_WIDTH-1:0] t;
      begin
         case (p)
            3'd0:    t = 8'd28;
            3'd1:    t = 8'd141;
            3'd2:    t = 8'd198;
            3'd3:    t = 8'd85;
            3'd4:    t = 8'd113;
            3'd5:    t = 8'd226;
            3'd6:    t = 8'd170;
            default: t = 8'd56;
         endcase
         return t;
      end
   endfunction

   // standard braille dot of each 2x4 position
   function automatic logic [GLYPH_WIDTH-1:0] dot_bit(input logic [POS_WIDTH-1:0] p);
      logic [GLYPH_WIDTH-1:0] d;
      begin
         case (p)
            3'd0:    d = 8'h01;
            3'd1:    d = 8'h08;
            3'd2:    d = 8'h02;
            3'd3:    d = 8'h10;
            3'd4:    d = 8'h04;
            3'd5:    d = 8'h20;
            3'd6:    d = 8'h40;
            default: d = 8'h80;
         endcase
         return d;
      end
   endfunction

   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [GLYPH_WIDTH-1:0] dots_ff, dots_in;
   logic [SUM_WIDTH-1:0]   red_sum_ff, red_sum_in;
   logic [SUM_WIDTH-1:0]   green_sum_ff, green_sum_in;
   logic [SUM_WIDTH-1:0]   blue_sum_ff, blue_sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [PIXEL_WIDTH-1:0] gray_v, red_v, green_v, blue_v;
   logic                   is_ramp, lit, accept, cell_done;
   logic [11:0]            gray_x10;
   logic [10:0]            gray_x5;
   logic [GLYPH_WIDTH-1:0] ramp_glyph, dots_next;
   logic [SUM_WIDTH-1:0]   red_next, green_next, blue_next;
   logic [COUNT_WIDTH-1:0] count_next;

   assign req_pixel.ready = !queue_full;

   always_comb begin
      gray_v  = cfg.invert_enable ? ~req_pixel.gray  : req_pixel.gray;
      red_v   = cfg.invert_enable ? ~req_pixel.red   : req_pixel.red;
      green_v = cfg.invert_enable ? ~req_pixel.green : req_pixel.green;
      blue_v  = cfg.invert_enable ? ~req_pixel.blue  : req_pixel.blue;

      is_ramp = (cfg.render_mode == MODE_ASCII) || (cfg.render_mode == MODE_SHADE);

      // gray*10/256 tops out at 9 and gray*5/256 at 4, so no clamp
      gray_x10 = {1'b0, gray_v, 3'b000} + {3'b000, gray_v, 1'b0};
      gray_x5  = {1'b0, gray_v, 2'b00} + {3'b000, gray_v};
      ramp_glyph = (cfg.render_mode == MODE_ASCII) ? {4'b0000, gray_x10[11:8]}
                                                   : {5'b00000, gray_x5[10:8]};

      lit        = gray_v > dither_threshold(pos_ff);
      dots_next  = lit ? (dots_ff | dot_bit(pos_ff)) : dots_ff;
      red_next   = lit ? red_sum_ff + SUM_WIDTH'(red_v) : red_sum_ff;
      green_next = lit ? green_sum_ff + SUM_WIDTH'(green_v) : green_sum_ff;
      blue_next  = lit ? blue_sum_ff + SUM_WIDTH'(blue_v) : blue_sum_ff;
      count_next = lit ? count_ff + COUNT_WIDTH'(1) : count_ff;

      accept    = req_pixel.valid && req_pixel.ready;
      cell_done = !is_ramp && (pos_ff == CELL_LAST);
      push      = accept && (is_ramp || cell_done);

      if (is_ramp) begin
         push_job.is_cell   = 1'b0;
         push_job.glyph     = ramp_glyph;
         push_job.red_sum   = SUM_WIDTH'(red_v);
         push_job.green_sum = SUM_WIDTH'(green_v);
         push_job.blue_sum  = SUM_WIDTH'(blue_v);
         push_job.lit_count = '0;
      end else begin
         push_job.is_cell   = 1'b1;
         push_job.glyph     = dots_next;
         push_job.red_sum   = red_next;
         push_job.green_sum = green_next;
         push_job.blue_sum  = blue_next;
         push_job.lit_count = count_next;
      end

      pos_in       = pos_ff;
      dots_in      = dots_ff;
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      count_in     = count_ff;
      if (accept) begin
         if (is_ramp || cell_done) begin
            // ramp pixels also drop any partial cell
            pos_in       = '0;
            dots_in      = '0;
            red_sum_in   = '0;
            green_sum_in = '0;
            blue_sum_in  = '0;
            count_in     = '0;
         end else begin
            pos_in       = pos_ff + POS_WIDTH'(1);
            dots_in      = dots_next;
            red_sum_in   = red_next;
            green_sum_in = green_next;
            blue_sum_in  = blue_next;
            count_in     = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         dots_ff      <= '0;
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         count_ff     <= '0;
      end else begin
         pos_ff       <= pos_in;
         dots_ff      <= dots_in;
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tcpr_queue.sv
// tcpr_queue: small job queue between the front and back parts
// depends on tcpr_pkg for the job type
`default_nettype none

module tcpr_queue import tcpr_pkg::*; #(
   parameter int DEPTH = TCPR_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire tcpr_job_type push_job,
   output logic              full,
   input  wire logic         pop,
   output tcpr_job_type      pop_job,
   output logic              empty
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]  PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FILL_MAX = COUNT_BITS'(DEPTH);

   tcpr_job_type           mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;

   assign full    = (fill_ff == FILL_MAX);
   assign empty   = (fill_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tcpr_back.sv
// tcpr_back: averages braille cell colors with a serial divider and maps colors
// depends on tcpr_pkg and tcpr_cell_if; pops jobs from tcpr_queue
`default_nettype none

module tcpr_back import tcpr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tcpr_cfg_type cfg,
   input  wire logic         queue_empty,
   input  wire tcpr_job_type pop_job,
   output logic              pop,
   tcpr_cell_if.source       rsp_cell
);

   localparam int CNT_WIDTH = $clog2(SUM_WIDTH);
   localparam logic [CNT_WIDTH-1:0]   DIV_LAST        = CNT_WIDTH'(SUM_WIDTH - 1);
   localparam logic [COLOR_WIDTH-1:0] CUBE_BASE       = 8'd16;
   localparam logic [COLOR_WIDTH-1:0] CUBE_RED_STEP   = 8'd36;
   localparam logic [COLOR_WIDTH-1:0] CUBE_GREEN_STEP = 8'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // (c*5 + 127) / 255 as thresholds on c
   function automatic logic [2:0] cube_level(input logic [PIXEL_WIDTH-1:0] c);
      logic [2:0] l;
      begin
         l = 3'd0;
         if (c >= 8'd26)  l = 3'd1;
         if (c >= 8'd77)  l = 3'd2;
         if (c >= 8'd128) l = 3'd3;
         if (c >= 8'd179) l = 3'd4;
         if (c >= 8'd230) l = 3'd5;
         return l;
      end
   endfunction

   state_type              state_ff, state_in;
   logic                   out_valid_ff, out_valid_in;
   logic [GLYPH_WIDTH-1:0] out_glyph_ff, out_glyph_in;
   logic                   out_blank_ff, out_blank_in;
   logic                   out_cvalid_ff, out_cvalid_in;
   logic [COLOR_WIDTH-1:0] out_cindex_ff, out_cindex_in;

   logic [GLYPH_WIDTH-1:0] dots_ff, dots_in;
   logic [COUNT_WIDTH-1:0] divisor_ff, divisor_in;
   logic [CNT_WIDTH-1:0]   step_ff, step_in;
   logic [SUM_WIDTH-1:0]   quo_ff [3];
   logic [SUM_WIDTH-1:0]   quo_in [3];
   logic [COUNT_WIDTH-1:0] rem_ff [3];
   logic [COUNT_WIDTH-1:0] rem_in [3];

   logic                   out_free, color_on, job_direct;
   logic [PIXEL_WIDTH-1:0] col_r, col_g, col_b;
   logic [COLOR_WIDTH-1:0] color_idx;
   logic [COUNT_WIDTH:0]   trial [3];

   assign rsp_cell.valid       = out_valid_ff;
   assign rsp_cell.glyph_code  = out_glyph_ff;
   assign rsp_cell.blank_cell  = out_blank_ff;
   assign rsp_cell.color_valid = out_cvalid_ff;
   assign rsp_cell.color_code  = out_cindex_ff;

   always_comb begin
      out_free   = !out_valid_ff || rsp_cell.ready;
      // ramp pixels and blank cells need no division
      job_direct = !pop_job.is_cell || (pop_job.lit_count == '0);

      if (state_ff == ST_FINISH) begin
         col_r = quo_ff[0][PIXEL_WIDTH-1:0];
         col_g = quo_ff[1][PIXEL_WIDTH-1:0];
         col_b = quo_ff[2][PIXEL_WIDTH-1:0];
      end else begin
         col_r = pop_job.red_sum[PIXEL_WIDTH-1:0];
         col_g = pop_job.green_sum[PIXEL_WIDTH-1:0];
         col_b = pop_job.blue_sum[PIXEL_WIDTH-1:0];
      end

      color_on = cfg.color_enable && cfg.frame_has_color && (cfg.palette_mode != PAL_NONE);
      if (cfg.palette_mode == PAL_BASIC) begin
         // each channel independently snaps to 0 or 255; 255 is odd so no ties
         color_idx = {5'b00000, col_b[PIXEL_WIDTH-1], col_g[PIXEL_WIDTH-1],
                      col_r[PIXEL_WIDTH-1]};
      end else begin
         color_idx = CUBE_BASE + {5'b00000, cube_level(col_r)} * CUBE_RED_STEP
                   + {5'b00000, cube_level(col_g)} * CUBE_GREEN_STEP
                   + {5'b00000, cube_level(col_b)};
      end

      // restoring division, one quotient bit per cycle on all three channels
      for (int ch = 0; ch < 3; ch++) begin
         trial[ch]  = {rem_ff[ch], quo_ff[ch][SUM_WIDTH-1]};
         quo_in[ch] = quo_ff[ch];
         rem_in[ch] = rem_ff[ch];
      end

      state_in      = state_ff;
      pop           = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_cell.ready;
      out_glyph_in  = out_glyph_ff;
      out_blank_in  = out_blank_ff;
      out_cvalid_in = out_cvalid_ff;
      out_cindex_in = out_cindex_ff;
      dots_in       = dots_ff;
      divisor_in    = divisor_ff;
      step_in       = step_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               if (job_direct) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     out_valid_in = 1'b1;
                     if (pop_job.is_cell) begin
                        out_glyph_in  = '0;
                        out_blank_in  = 1'b1;
                        out_cvalid_in = 1'b0;
                        out_cindex_in = '0;
                     end else begin
                        out_glyph_in  = pop_job.glyph;
                        out_blank_in  = 1'b0;
                        out_cvalid_in = color_on;
                        out_cindex_in = color_on ? color_idx : '0;
                     end
                  end
               end else begin
                  pop        = 1'b1;
                  dots_in    = pop_job.glyph;
                  divisor_in = pop_job.lit_count;
                  step_in    = '0;
                  quo_in[0]  = pop_job.red_sum;
                  quo_in[1]  = pop_job.green_sum;
                  quo_in[2]  = pop_job.blue_sum;
                  for (int ch = 0; ch < 3; ch++) begin
                     rem_in[ch] = '0;
                  end
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            for (int ch = 0; ch < 3; ch++) begin
               if (trial[ch] >= {1'b0, divisor_ff}) begin
                  rem_in[ch] = COUNT_WIDTH'(trial[ch] - {1'b0, divisor_ff});
                  quo_in[ch] = {quo_ff[ch][SUM_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in[ch] = trial[ch][COUNT_WIDTH-1:0];
                  quo_in[ch] = {quo_ff[ch][SUM_WIDTH-2:0], 1'b0};
               end
            end
            step_in = step_ff + CNT_WIDTH'(1);
            if (step_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_glyph_in  = dots_ff;
               out_blank_in  = 1'b0;
               out_cvalid_in = color_on;
               out_cindex_in = color_on ? color_idx : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_glyph_ff  <= out_glyph_in;
      out_blank_ff  <= out_blank_in;
      out_cvalid_ff <= out_cvalid_in;
      out_cindex_ff <= out_cindex_in;
      dots_ff       <= dots_in;
      divisor_ff    <= divisor_in;
      step_ff       <= step_in;
      for (int ch = 0; ch < 3; ch++) begin
         quo_ff[ch] <= quo_in[ch];
         rem_ff[ch] <= rem_in[ch];
      end
   end

endmodule

`default_nettype wire

FILE: sv/terminal_cell_pixel_renderer.sv
// terminal_cell_pixel_renderer: top level, register file plus front, queue and back
// depends on tcpr_pkg, tcpr_pixel_if, tcpr_cell_if, tcpr_front, tcpr_queue, tcpr_back
`default_nettype none

//  channel     direction  handshake           payload
//  req_pixel   in         valid/ready         gray, red, green, blue (8 bits each)
//  rsp_cell    out        valid/ready         glyph_code, blank_cell, color_valid,
//                                             color_code
//  csr         in         csr_write_enable    csr_index (3 bits), csr_write_data (2 bits)
//
//  ramp modes: one pixel per cycle in, one cell per cycle out while the receiver is ready;
//  results pass the queue and the output register. braille: eight pixels per cell; the
//  back part pops a lit cell, runs 11 divider steps for the color average and loads the
//  output before the next pop, so pixels stream at full rate until the queue fills
//  reset (synchronous) loads register defaults, empties queue and drops any partial cell
//  either side may stall; the queue lets the front keep accepting while back works

module terminal_cell_pixel_renderer import tcpr_pkg::*; #(
   parameter int QUEUE_DEPTH = TCPR_QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tcpr_pixel_if.sink                      req_pixel,
   tcpr_cell_if.source                     rsp_cell,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   tcpr_cfg_type cfg_ff, cfg_in;

   logic         push, pop, queue_full, queue_empty;
   tcpr_job_type push_job, pop_job;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RENDER_MODE:     cfg_in.render_mode     = csr_write_data[1:0];
            CSR_INVERT_ENABLE:   cfg_in.invert_enable   = csr_write_data[0];
            CSR_COLOR_ENABLE:    cfg_in.color_enable    = csr_write_data[0];
            CSR_FRAME_HAS_COLOR: cfg_in.frame_has_color = csr_write_data[0];
            CSR_PALETTE_MODE:    cfg_in.palette_mode    = csr_write_data[1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: inversion, ramp glyphs, braille dots and color sums
   tcpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_pixel  (req_pixel),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // decoupling queue between the two halves
   tcpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   // back: color average, palette mapping and output register
   tcpr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_cell    (rsp_cell)
   );

endmodule

`default_nettype wire

FILE: sv/tcpr_checker.sv
// tcpr_checker: port level assertions for terminal_cell_pixel_renderer
// depends on tcpr_pkg; bound to the top level at the end of this file
`default_nettype none

module tcpr_checker import tcpr_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [GLYPH_WIDTH-1:0] glyph_code,
   input wire logic                   blank_cell,
   input wire logic                   color_valid,
   input wire logic [COLOR_WIDTH-1:0] color_code
);

   localparam logic [COLOR_WIDTH-1:0] COLOR_MAX = 8'd231;

   // stalled cell holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(glyph_code) && $stable(blank_cell)
         && $stable(color_valid) && $stable(color_code))
      else $error("stalled cell changed");

   // nothing pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("cell valid after reset");

   // a blank cell carries no glyph and no color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && blank_cell |-> glyph_code == '0 && !color_valid && color_code == '0)
      else $error("blank cell with glyph or color");

   // color code is zero without color and never past the cube's top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (color_valid || color_code == '0) && color_code <= COLOR_MAX)
      else $error("color code out of range");

endmodule

bind terminal_cell_pixel_renderer tcpr_checker u_tcpr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_cell.valid),
   .rsp_ready   (rsp_cell.ready),
   .glyph_code  (rsp_cell.glyph_code),
   .blank_cell  (rsp_cell.blank_cell),
   .color_valid (rsp_cell.color_valid),
   .color_code  (rsp_cell.color_code)
);

`default_nettype wire

FILE: tb/tb_terminal_cell_pixel_renderer.sv
// tb_terminal_cell_pixel_renderer: self-checking bench for the terminal cell pixel renderer
// drives pixels through directed rows and random config phases, predicts every cell
// depends on tcpr_pkg, tcpr_pixel_if, tcpr_cell_if and terminal_cell_pixel_renderer
`timescale 1ns / 100ps

module tb_terminal_cell_pixel_renderer;
   import tcpr_pkg::*;

   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 24;    // a braille cell passes pop, divider steps and output load in the back end
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int LONG_HOLD      = 250;   // receiver back-pressure stretch
   localparam int PRESSURE_PHASE = 4;
   localparam int RANDOM_PIXELS  = 500;

   // register indexes with no register behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] FIRST_SPARE_CSR = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] LAST_SPARE_CSR  = 3'd7;

   // braille cell in row-major order: position = 2 * subrow + subcolumn
   localparam int         DITHER_ORDER [8] = '{0, 4, 6, 2, 3, 7, 5, 1};
   localparam logic [7:0] DOT_BIT      [8] = '{8'h01, 8'h08, 8'h02, 8'h10,
                                               8'h04, 8'h20, 8'h40, 8'h80};

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] gray;
      logic [PIXEL_WIDTH-1:0] red;
      logic [PIXEL_WIDTH-1:0] green;
      logic [PIXEL_WIDTH-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [GLYPH_WIDTH-1:0] glyph_code;
      logic                   blank_cell;
      logic                   color_valid;
      logic [COLOR_WIDTH-1:0] color_code;
   } cell_result_type;

   typedef struct packed {
      tcpr_cfg_type    cfg;
      pixel_type       px;
      logic [3:0]      count;   // the same pixel sent this many times
      logic            typed;   // want holds the result of the last pixel
      cell_result_type want;
   } stim_row_type;

   // settings used by the directed rows
   localparam tcpr_cfg_type CFG_ASCII_CUBE  = '{MODE_ASCII, 1'b0, 1'b1, 1'b1, PAL_CUBE};
   localparam tcpr_cfg_type CFG_ASCII_BASIC = '{MODE_ASCII, 1'b0, 1'b1, 1'b1, PAL_BASIC};
   localparam tcpr_cfg_type CFG_ASCII_INV   = '{MODE_ASCII, 1'b1, 1'b1, 1'b1, PAL_BASIC};
   localparam tcpr_cfg_type CFG_ASCII_OFF   = '{MODE_ASCII, 1'b0, 1'b0, 1'b1, PAL_CUBE};
   localparam tcpr_cfg_type CFG_ASCII_NOPAL = '{MODE_ASCII, 1'b0, 1'b1, 1'b1, PAL_NONE};
   localparam tcpr_cfg_type CFG_BRAILLE     = '{MODE_BRAILLE, 1'b0, 1'b1, 1'b1, PAL_CUBE};

   localparam int DIRECTED_COUNT = 15;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // reset settings: shade ramp, mono frame so no color
      '{CFG_RESET,       '{8'd0,   8'd0,   8'd0,   8'd0},   4'd1, 1'b1,
        '{8'd0,   1'b0, 1'b0, 8'd0}},
      '{CFG_RESET,       '{8'd255, 8'd255, 8'd255, 8'd255}, 4'd1, 1'b1,
        '{8'd4,   1'b0, 1'b0, 8'd0}},
      // ascii ramp with the color cube, both corners of the cube
      '{CFG_ASCII_CUBE,  '{8'd255, 8'd255, 8'd255, 8'd255}, 4'd1, 1'b1,
        '{8'd9,   1'b0, 1'b1, 8'd231}},
      '{CFG_ASCII_CUBE,  '{8'd0,   8'd0,   8'd0,   8'd0},   4'd1, 1'b1,
        '{8'd0,   1'b0, 1'b1, 8'd16}},
      '{CFG_ASCII_CUBE,  '{8'd128, 8'd200, 8'd30,  8'd90},  4'd1, 1'b0, '0},
      // eight basic colors: pure red, then mid gray
      '{CFG_ASCII_BASIC, '{8'd77,  8'd255, 8'd0,   8'd0},   4'd1, 1'b1,
        '{8'd3,   1'b0, 1'b1, 8'd1}},
      '{CFG_ASCII_BASIC, '{8'd128, 8'd128, 8'd128, 8'd128}, 4'd1, 1'b0, '0},
      // inverted black turns into full white
      '{CFG_ASCII_INV,   '{8'd0,   8'd0,   8'd0,   8'd0},   4'd1, 1'b1,
        '{8'd9,   1'b0, 1'b1, 8'd7}},
      // color switched off, then a terminal without colors
      '{CFG_ASCII_OFF,   '{8'd200, 8'd10,  8'd200, 8'd90},  4'd1, 1'b1,
        '{8'd7,   1'b0, 1'b0, 8'd0}},
      '{CFG_ASCII_NOPAL, '{8'd100, 8'd40,  8'd80,  8'd160}, 4'd1, 1'b1,
        '{8'd3,   1'b0, 1'b0, 8'd0}},
      // braille: every dot lit, then a blank cell
      '{CFG_BRAILLE,     '{8'd255, 8'd255, 8'd0,   8'd0},   4'd8, 1'b1,
        '{8'hff,  1'b0, 1'b1, 8'd196}},
      '{CFG_BRAILLE,     '{8'd0,   8'd0,   8'd0,   8'd0},   4'd8, 1'b1,
        '{8'd0,   1'b1, 1'b0, 8'd0}},
      // partial cell, a ramp pixel wipes it, then a fresh partial cell
      '{CFG_BRAILLE,     '{8'd200, 8'd30,  8'd160, 8'd220}, 4'd3, 1'b0, '0},
      '{CFG_ASCII_CUBE,  '{8'd128, 8'd60,  8'd120, 8'd240}, 4'd1, 1'b0, '0},
      '{CFG_BRAILLE,     '{8'd150, 8'd90,  8'd20,  8'd250}, 4'd5, 1'b0, '0}
   };

   logic clock;
   logic reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   tcpr_pixel_if pixel_ch ();
   tcpr_cell_if  cell_ch ();

   terminal_cell_pixel_renderer dut (
      .clock            (clock),
      .reset            (reset),
      .req_pixel        (pixel_ch),
      .rsp_cell         (cell_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state: register copy plus the braille accumulation
   tcpr_cfg_type           model_cfg;
   logic [POS_WIDTH-1:0]   cell_pos;
   logic [7:0]             cell_dots;
   logic [SUM_WIDTH-1:0]   red_sum;
   logic [SUM_WIDTH-1:0]   green_sum;
   logic [SUM_WIDTH-1:0]   blue_sum;
   logic [COUNT_WIDTH-1:0] lit_count;

   cell_result_type pending_cells [$];
   int failures     = 0;
   int quiet_cycles = 0;
   bit hold_pending = 1'b0;   // asks the receiver for one long stall

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_cell_model();
      cell_pos  = '0;
      cell_dots = '0;
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      lit_count = '0;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                          input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_RENDER_MODE:     model_cfg.render_mode     = data;
         CSR_INVERT_ENABLE:   model_cfg.invert_enable   = data[0];
         CSR_COLOR_ENABLE:    model_cfg.color_enable    = data[0];
         CSR_FRAME_HAS_COLOR: model_cfg.frame_has_color = data[0];
         CSR_PALETTE_MODE:    model_cfg.palette_mode    = data;
         default: ;   // spare index, nothing changes
      endcase
   endfunction

   // nearest corner of the rgb cube; ties go to the lower color number
   function automatic logic [7:0] closest_corner_color(input int r, input int g, input int b);
      int best;
      int best_err;
      int sq_err;
      int dr;
      int dg;
      int db;
      best     = 7;
      best_err = 32'h7fff_ffff;
      for (int i = 0; i < 8; i++) begin
         dr     = r - (i[0] ? 255 : 0);
         dg     = g - (i[1] ? 255 : 0);
         db     = b - (i[2] ? 255 : 0);
         sq_err = dr * dr + dg * dg + db * db;
         if (sq_err < best_err) begin
            best_err = sq_err;
            best     = i;
         end
      end
      return 8'(best);
   endfunction

   function automatic int cube_level(input int c);
      return (c * 5 + 127) / 255;
   endfunction

   function automatic void color_of(input int r, input int g, input int b,
                                    output logic valid, output logic [7:0] index);
      valid = 1'b0;
      index = '0;
      if (model_cfg.color_enable && model_cfg.frame_has_color &&
          model_cfg.palette_mode != PAL_NONE) begin
         valid = 1'b1;
         if (model_cfg.palette_mode == PAL_BASIC)
            index = closest_corner_color(r, g, b);
         else   // cube, also the spare palette code
            index = 8'(16 + 36 * cube_level(r) + 6 * cube_level(g) + cube_level(b));
      end
   endfunction

   // advance the predictor by one pixel; returns 1 when a cell comes out
   function automatic bit render_pixel(input pixel_type px, output cell_result_type result);
      int         gray;
      int         red;
      int         green;
      int         blue;
      int         glyph;
      int         threshold;
      logic       cv;
      logic [7:0] ci;
      gray   = px.gray;
      red    = px.red;
      green  = px.green;
      blue   = px.blue;
      result = '0;
      if (model_cfg.invert_enable) begin
         gray  = 255 - gray;
         red   = 255 - red;
         green = 255 - green;
         blue  = 255 - blue;
      end
      if (model_cfg.render_mode == MODE_ASCII || model_cfg.render_mode == MODE_SHADE) begin
         // a ramp pixel always throws away any half-built braille cell
         clear_cell_model();
         if (model_cfg.render_mode == MODE_ASCII) begin
            glyph = gray * 10 / 256;
            if (glyph > 9) glyph = 9;
         end else begin
            glyph = gray * 5 / 256;
            if (glyph > 4) glyph = 4;
         end
         color_of(red, green, blue, cv, ci);
         result.glyph_code  = 8'(glyph);
         result.color_valid = cv;
         result.color_code  = ci;
         return 1'b1;
      end
      // braille, also the spare mode code
      threshold = (DITHER_ORDER[cell_pos] + 1) * 255 / 9;
      if (gray > threshold) begin
         cell_dots = cell_dots | DOT_BIT[cell_pos];
         red_sum   = red_sum + SUM_WIDTH'(red);
         green_sum = green_sum + SUM_WIDTH'(green);
         blue_sum  = blue_sum + SUM_WIDTH'(blue);
         lit_count = lit_count + 1'b1;
      end
      if (cell_pos != 3'd7) begin
         cell_pos = cell_pos + 1'b1;
         return 1'b0;
      end
      if (cell_dots == '0 || lit_count == '0) begin
         result.blank_cell = 1'b1;
      end else begin
         color_of(int'(red_sum) / int'(lit_count) % 256,
                  int'(green_sum) / int'(lit_count) % 256,
                  int'(blue_sum) / int'(lit_count) % 256, cv, ci);
         result.glyph_code  = cell_dots;
         result.color_valid = cv;
         result.color_code  = ci;
      end
      clear_cell_model();
      return 1'b1;
   endfunction

   function automatic pixel_type random_pixel(input bit dark);
      pixel_type px;
      int        pick;
      pick = $urandom_range(0, 9);
      if (dark)
         px.gray = 8'($urandom_range(0, 28));   // under every dither threshold
      else if (pick == 0)
         px.gray = 8'd0;
      else if (pick == 1)
         px.gray = 8'd255;
      else if (pick < 4)   // right around one of the thresholds
         px.gray = 8'($urandom_range(1, 8) * 255 / 9 + $urandom_range(0, 2) - 1);
      else
         px.gray = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         // mono frame: channels follow gray
         px.red   = px.gray;
         px.green = px.gray;
         px.blue  = px.gray;
      end else begin
         px.red   = 8'($urandom);
         px.green = 8'($urandom);
         px.blue  = 8'($urandom);
      end
      return px;
   endfunction

   function automatic void compare_field(input string field, input logic [7:0] want,
                                         input logic [7:0] seen);
      if (seen !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
      end
   endfunction

   // one pixel transfer; the predictor runs at the accepting edge
   task automatic send_pixel(input pixel_type px, input bit calm, input bit typed,
                             input cell_result_type typed_result);
      int              gap;
      cell_result_type predicted;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         pixel_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pixel_ch.valid <= 1'b1;
      pixel_ch.gray  <= px.gray;
      pixel_ch.red   <= px.red;
      pixel_ch.green <= px.green;
      pixel_ch.blue  <= px.blue;
      do @(posedge clock); while (pixel_ch.ready !== 1'b1);
      if (render_pixel(px, predicted))
         pending_cells.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   // block is quiet: no cell outstanding and time for a half-built cell to settle
   task automatic wait_idle();
      pixel_ch.valid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      store_register(index, data);
      @(negedge clock);
   endtask

   // write all five registers; unused upper data bits of one-bit registers are random
   task automatic apply_config(input tcpr_cfg_type cfg);
      wait_idle();
      write_csr(CSR_RENDER_MODE, cfg.render_mode);
      write_csr(CSR_INVERT_ENABLE, {1'($urandom_range(0, 1)), cfg.invert_enable});
      write_csr(CSR_COLOR_ENABLE, {1'($urandom_range(0, 1)), cfg.color_enable});
      write_csr(CSR_FRAME_HAS_COLOR, {1'($urandom_range(0, 1)), cfg.frame_has_color});
      write_csr(CSR_PALETTE_MODE, cfg.palette_mode);
      if ($urandom_range(0, 2) == 0)   // spare index must be ignored
         write_csr(CSR_INDEX_WIDTH'($urandom_range(FIRST_SPARE_CSR, LAST_SPARE_CSR)),
                   CSR_DATA_WIDTH'($urandom_range(0, 3)));
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stalls, calm runs, one long hold on request
   initial begin : cell_sink
      int              stall;
      int              calm_left;
      cell_result_type seen;
      cell_ch.ready = 1'b0;
      calm_left     = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            stall        = LONG_HOLD;
            hold_pending = 1'b0;
         end else if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else begin
            if ($urandom_range(0, 9) == 0) calm_left = 24;
            stall = $urandom_range(0, 6);
         end
         if (stall > 0) begin
            cell_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         cell_ch.ready <= 1'b1;
         do @(posedge clock); while (cell_ch.valid !== 1'b1);
         seen = '{cell_ch.glyph_code, cell_ch.blank_cell, cell_ch.color_valid,
                  cell_ch.color_code};
         if (pending_cells.size() == 0) begin
            failures++;
            $display("%0t: unexpected cell, glyph %0d blank %0d color %0d code %0d",
                     $time, seen.glyph_code, seen.blank_cell, seen.color_valid,
                     seen.color_code);
         end else begin
            cell_result_type want;
            want = pending_cells.pop_front();
            compare_field("glyph_code", want.glyph_code, seen.glyph_code);
            compare_field("blank_cell", want.blank_cell, seen.blank_cell);
            compare_field("color_valid", want.color_valid, seen.color_valid);
            compare_field("color_code", want.color_code, seen.color_code);
         end
         @(negedge clock);
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (pixel_ch.valid && pixel_ch.ready) || (cell_ch.valid && cell_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d cells outstanding",
                  $time, quiet_cycles, pending_cells.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      tcpr_cfg_type cfg;
      stim_row_type row;
      int           phase;
      int           count;
      int           random_pixels;
      bit           calm;
      bit           dark;

      pixel_ch.valid = 1'b0;
      pixel_ch.gray  = '0;
      pixel_ch.red   = '0;
      pixel_ch.green = '0;
      pixel_ch.blue  = '0;
      model_cfg      = CFG_RESET;
      clear_cell_model();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; a settings change drains the block first
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.cfg != model_cfg) apply_config(row.cfg);
         for (int k = 0; k < row.count; k++)
            send_pixel(row.px, 1'b0, row.typed && k == row.count - 1, row.want);
      end

      // random phases: early ones sweep every register value, later ones are free;
      // phase lengths need not be multiples of eight so cells can straddle register writes
      random_pixels = 0;
      for (phase = 0; random_pixels < RANDOM_PIXELS; phase++) begin
         if (phase < 8) begin
            cfg.render_mode     = 2'(phase);
            cfg.palette_mode    = 2'(phase + phase / 4);
            cfg.invert_enable   = 1'((phase / 2) % 2);
            cfg.color_enable    = (phase % 3 != 2);
            cfg.frame_has_color = (phase % 5 != 4);
         end else begin
            cfg.render_mode     = 2'($urandom_range(0, 3));
            cfg.palette_mode    = 2'($urandom_range(0, 3));
            cfg.invert_enable   = 1'($urandom_range(0, 1));
            cfg.color_enable    = ($urandom_range(0, 4) != 0);
            cfg.frame_has_color = ($urandom_range(0, 4) != 0);
         end
         apply_config(cfg);
         calm = ($urandom_range(0, 3) == 0) || phase == PRESSURE_PHASE;
         // back-pressure: the sender keeps offering while the receiver holds off
         if (phase == PRESSURE_PHASE) hold_pending = 1'b1;
         if (cfg.render_mode == MODE_ASCII || cfg.render_mode == MODE_SHADE)
            count = $urandom_range(20, 40);
         else
            count = $urandom_range(40, 70);
         dark = 1'b0;
         for (int k = 0; k < count; k++) begin
            // dark groups give blank braille cells now and then
            if (k % 8 == 0) dark = ($urandom_range(0, 5) == 0);
            send_pixel(random_pixel(dark), calm, 1'b0, '0);
         end
         random_pixels += count;
      end

      wait_idle();
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
